// ===== rtl/ieel_pkg.sv =====
// Package for the indexed insert/erase list.
// Holds opcodes, status codes, field widths and the cell control struct.
// No dependencies.
package ieel_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic wr;   // overwrite the entry at the position
    logic ins;  // shift up from the position, load value there
    logic ers;  // shift down from the position
  } cell_ctrl_t;

endpackage

// ===== rtl/ieel_cell.sv =====
// One storage cell of the list: holds one entry and shifts with its neighbors.
// Depends on ieel_pkg.
module ieel_cell
  import ieel_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int INDEX    = 0,
  localparam int PW      = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [PW-1:0]      pos,
  input  logic [VALUE_W-1:0] value,
  input  logic [VALUE_W-1:0] left_in,
  input  logic [VALUE_W-1:0] right_in,
  output logic [VALUE_W-1:0] entry,
  output logic [VALUE_W-1:0] rd_tap
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               at_pos;
  logic               above_pos;

  assign at_pos    = (pos == IDX);
  assign above_pos = (IDX > pos);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (at_pos) entry_nxt = value;
      else if (above_pos) entry_nxt = left_in;
    end else if (ctrl.ers) begin
      if (at_pos || above_pos) entry_nxt = right_in;
    end else if (ctrl.wr) begin
      if (at_pos) entry_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry  = entry_r;
  assign rd_tap = at_pos ? entry_r : '0;

endmodule

// ===== rtl/indexed_insert_erase_list.sv =====
// Channel | dir | fields (tdata from bit 0 up)
// in_     | in  | opcode, position, value
// out_    | out | read_value, status, fill_count
// One transfer per cycle sustained while out_tready does not hold the output register.
// Result appears in the output register the cycle after the input transfer.
// Longest path: the read-tap OR across all cells into the output register.
// Synchronous active-low reset clears the count and the output valid.
// An input transfer is taken whenever the output register is empty or draining.
// Depends on ieel_pkg and ieel_cell.
module indexed_insert_erase_list
  import ieel_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int PW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int IN_W    = ((OPCODE_W + PW + VALUE_W + 7) / 8) * 8,
  localparam int OUT_W   = ((VALUE_W + STATUS_W + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // opcode, position, value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // read_value, status, fill_count
);

  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  logic [OPCODE_W-1:0]       in_op;
  logic [PW-1:0]             in_pos;
  logic signed [VALUE_W-1:0] in_val;
  logic                      xfer;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      pos_ext;
  logic               full;
  logic               empty;

  cell_ctrl_t         ctrl;
  logic [PW-1:0]      act_pos;
  logic               take_rd;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0] rd_any;

  logic [VALUE_W-1:0] ent [CAPACITY];
  logic [VALUE_W-1:0] tap [CAPACITY];

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  assign in_op  = in_tdata[OPCODE_W-1:0];
  assign in_pos = in_tdata[OPCODE_W +: PW];
  assign in_val = in_tdata[OPCODE_W + PW +: VALUE_W];

  assign in_tready = !out_valid_r || out_tready;
  assign xfer      = in_tvalid && in_tready;

  assign count_m1 = count_r - CW'(1);
  assign pos_ext  = CW'(in_pos);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  always_comb begin
    ctrl      = '0;
    act_pos   = in_pos;
    take_rd   = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    unique case (in_op)
      OP_APPEND: begin
        act_pos = count_r[PW-1:0];
        if (full) status = ST_FULL;
        else begin
          ctrl.ins  = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        act_pos = count_m1[PW-1:0];
        if (empty) status = ST_EMPTY;
        else begin
          ctrl.ers  = 1'b1;
          take_rd   = 1'b1;
          count_nxt = count_m1;
        end
      end
      OP_READ, OP_WRITE, OP_ERASE: begin
        if (empty) status = ST_EMPTY;
        else if (pos_ext >= count_r) status = ST_RANGE;
        else begin
          priority if (in_op == OP_READ) take_rd = 1'b1;
          else if (in_op == OP_WRITE) ctrl.wr = 1'b1;
          else begin
            ctrl.ers  = 1'b1;
            count_nxt = count_m1;
          end
        end
      end
      OP_INSERT: begin
        if (full) status = ST_FULL;
        else if (pos_ext > count_r) status = ST_RANGE;
        else begin
          ctrl.ins  = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
    if (!xfer) ctrl = '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_n;
    logic [VALUE_W-1:0] right_n;
    if (i == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid_l
      assign left_n = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_mid_r
      assign right_n = ent[i+1];
    end
    ieel_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (act_pos),
      .value    (in_val),
      .left_in  (left_n),
      .right_in (right_n),
      .entry    (ent[i]),
      .rd_tap   (tap[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_data_r <= OUT_W'({count_nxt, status, (take_rd ? rd_any : {VALUE_W{1'b0}})});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for indexed_insert_erase_list: directed table, then random traffic.
// Shadow list predicts every response but those of fixed directed rows; random stalls on both stream sides.
// Depends on ieel_pkg and the indexed_insert_erase_list RTL.
`timescale 1ns / 100ps

module tb_top;
  import ieel_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IN_W       = 80;
  localparam int OUT_W      = 80;
  localparam int RAND_ITEMS = 1450;
  localparam int QUIET_TAIL = 200;
  localparam int LONG_HOLD  = 300;
  localparam int CYCLE_MAX  = 400000;

  localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [2:0]  OP_UNUSED = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

  typedef struct packed {
    logic [63:0] rd;
    logic [1:0]  st;
    logic [6:0]  cnt;
  } list_resp_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  pos;
    logic [63:0] val;
    logic        fixed;
    list_resp_t  resp;
  } list_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // opcode, position, value
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // read_value, status, fill_count

  logic [63:0] shadow_list [0:DEPTH-1];
  int          shadow_count;
  list_resp_t  pending_resp [$];
  list_req_t   dir_tab [$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          cycle_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  bit          started = 1'b0;

  indexed_insert_erase_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic list_resp_t list_apply(logic [2:0] op, logic [5:0] pos, logic [63:0] val);
    list_resp_t r;
    int i;
    r.rd = '0;
    r.st = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.rd = shadow_list[shadow_count-1];
          shadow_list[shadow_count-1] = '0;
          shadow_count--;
        end
      end
      OP_READ, OP_WRITE, OP_ERASE: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          r.st = ST_RANGE;
        end else if (op == OP_READ) begin
          r.rd = shadow_list[pos];
        end else if (op == OP_WRITE) begin
          shadow_list[pos] = val;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_list[shadow_count-1] = '0;
          shadow_count--;
        end
      end
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.st = ST_FULL;
        end else if (int'(pos) > shadow_count) begin
          r.st = ST_RANGE;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_count++;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.cnt = shadow_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    list_resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rd  = out_tdata[63:0];
      got.st  = out_tdata[65:64];
      got.cnt = out_tdata[72:66];
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(got), '0);
      end else begin
        want = pending_resp.pop_front();
        if (got.rd !== want.rd) report_mismatch("read_value", got.rd, want.rd);
        if (got.st !== want.st) report_mismatch("status", 64'(got.st), 64'(want.st));
        if (got.cnt !== want.cnt) report_mismatch("fill_count", 64'(got.cnt), 64'(want.cnt));
      end
    end
  end

  task automatic add_row(logic [2:0] op, logic [5:0] pos, logic [63:0] val, logic fixed,
                         logic [63:0] rd, logic [1:0] st, logic [6:0] cnt);
    list_req_t row;
    row.op = op;
    row.pos = pos;
    row.val = val;
    row.fixed = fixed;
    row.resp.rd = rd;
    row.resp.st = st;
    row.resp.cnt = cnt;
    dir_tab = {dir_tab, row};
  endtask

  task automatic send_item(list_req_t req);
    list_resp_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tdata <= {7'd0, req.val, req.pos, req.op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = list_apply(req.op, req.pos, req.val);
    pending_resp = {pending_resp, (req.fixed ? req.resp : pred)};
    sent_cnt++;
  endtask

  function automatic logic [2:0] pick_op(mix_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return OP_CLEAR;
    if (r < 2) return OP_UNUSED;
    case (mode)
      MODE_GROW: begin
        if (r < 45) return OP_APPEND;
        if (r < 85) return OP_INSERT;
        if (r < 92) return OP_READ;
        if (r < 96) return OP_WRITE;
        return (r < 98) ? OP_ERASE : OP_REMOVE;
      end
      MODE_SHRINK: begin
        if (r < 40) return OP_REMOVE;
        if (r < 80) return OP_ERASE;
        if (r < 88) return OP_READ;
        if (r < 94) return OP_WRITE;
        return (r < 97) ? OP_APPEND : OP_INSERT;
      end
      default: begin
        if (r < 18) return OP_APPEND;
        if (r < 33) return OP_REMOVE;
        if (r < 53) return OP_READ;
        if (r < 68) return OP_WRITE;
        if (r < 84) return OP_INSERT;
        return OP_ERASE;
      end
    endcase
  endfunction

  function automatic logic [63:0] pick_val();
    case ($urandom_range(0, 11))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    list_req_t req;
    mix_mode_t mode;
    int k;
    shadow_count = 0;
    for (k = 0; k < DEPTH; k++) shadow_list[k] = '0;

    add_row(OP_REMOVE, 6'd0,  VAL_ONES, 1'b1, '0, ST_EMPTY, 7'd0);
    add_row(OP_READ,   6'd0,  '0,       1'b1, '0, ST_EMPTY, 7'd0);
    add_row(OP_WRITE,  6'd5,  VAL_MAX,  1'b1, '0, ST_EMPTY, 7'd0);
    add_row(OP_ERASE,  6'd0,  '0,       1'b1, '0, ST_EMPTY, 7'd0);
    add_row(OP_INSERT, 6'd1,  VAL_MAX,  1'b1, '0, ST_RANGE, 7'd0);
    add_row(OP_INSERT, 6'd0,  VAL_MAX,  1'b1, '0, ST_OK,    7'd1);
    add_row(OP_APPEND, 6'd63, VAL_MIN,  1'b1, '0, ST_OK,    7'd2);
    add_row(OP_APPEND, 6'd0,  VAL_ONES, 1'b1, '0, ST_OK,    7'd3);
    add_row(OP_READ,   6'd0,  VAL_ONES, 1'b1, VAL_MAX, ST_OK, 7'd3);
    add_row(OP_READ,   6'd1,  '0,       1'b1, VAL_MIN, ST_OK, 7'd3);
    add_row(OP_READ,   6'd3,  '0,       1'b1, '0, ST_RANGE, 7'd3);
    add_row(OP_READ,   6'd63, '0,       1'b1, '0, ST_RANGE, 7'd3);
    add_row(OP_INSERT, 6'd3,  64'h5555_5555_5555_5555, 1'b1, '0, ST_OK, 7'd4);
    add_row(OP_INSERT, 6'd5,  VAL_MAX,  1'b1, '0, ST_RANGE, 7'd4);
    add_row(OP_INSERT, 6'd1,  64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0, ST_OK, 7'd0);
    add_row(OP_WRITE,  6'd0,  '0,       1'b0, '0, ST_OK, 7'd0);
    add_row(OP_WRITE,  6'd5,  VAL_ONES, 1'b1, '0, ST_RANGE, 7'd5);
    add_row(OP_ERASE,  6'd1,  '0,       1'b0, '0, ST_OK, 7'd0);
    add_row(OP_READ,   6'd1,  '0,       1'b0, '0, ST_OK, 7'd0);
    add_row(OP_REMOVE, 6'd0,  '0,       1'b0, '0, ST_OK, 7'd0);
    add_row(OP_UNUSED, 6'd63, VAL_ONES, 1'b1, '0, ST_OK, 7'd3);
    add_row(OP_ERASE,  6'd0,  '0,       1'b0, '0, ST_OK, 7'd0);
    add_row(OP_CLEAR,  6'd0,  VAL_ONES, 1'b1, '0, ST_OK, 7'd0);
    add_row(OP_READ,   6'd0,  '0,       1'b1, '0, ST_EMPTY, 7'd0);
    add_row(OP_CLEAR,  6'd63, '0,       1'b1, '0, ST_OK, 7'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    started = 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    for (k = 0; k < RAND_ITEMS; k++) begin
      case ((k / 120) % 3)
        0: mode = MODE_GROW;
        1: mode = MODE_SHRINK;
        default: mode = MODE_MIXED;
      endcase
      if (k == 700) begin
        // drain everything before continuing
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_resp.size() != 0) @(posedge clk);
      end
      if (k >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      req.op = pick_op(mode);
      if ($urandom_range(0, 3) == 0) begin
        req.pos = 6'($urandom_range(0, 63));
      end else begin
        req.pos = 6'($urandom_range(0, (shadow_count > 63) ? 63 : shadow_count));
      end
      req.val = pick_val();
      req.fixed = 1'b0;
      req.resp = '0;
      send_item(req);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (started);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!hold_done && sent_cnt >= 400) begin
        // long back-pressure while the sender keeps offering
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

endmodule

// ===== files.f =====
rtl/ieel_pkg.sv
rtl/ieel_cell.sv
rtl/indexed_insert_erase_list.sv
tb/sv/tb_top.sv
